// ===== rtl/cvw_pkg.sv =====
// cvw_pkg: shared types and constants for the corner vertex welder
// payload structs for the input and result transfers, hash constants
// no dependencies
package cvw_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    localparam int unsigned SCALE_W = 21;
    localparam int unsigned ID_W = 12;

    typedef struct packed {
        logic               new_set;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } point_t;

    typedef struct packed {
        logic [11:0] vertex_id;
        logic        inserted;
        logic        overflow;
    } result_t;

endpackage

// ===== rtl/corner_vertex_welder.sv =====
// corner_vertex_welder: top level, welds corner points into shared vertex ids
// one transfer at a time: a new point is taken only once the last result has left,
// paced by the three-step hash multiply sequencer and the probe loop
// after reset a clearing pass over every table entry runs before the first point
// a new_set every 255 sets repeats that pass; weld_scale resets to 100000
// depends on cvw_pkg, cvw_hash, cvw_table
module corner_vertex_welder #(
    parameter int unsigned TABLE_ENTRIES   = 4096,
    parameter int unsigned COORD_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cvw_pkg::SCALE_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  cvw_pkg::point_t                in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output cvw_pkg::result_t               out_data
);

    logic [cvw_pkg::SCALE_W-1:0] scale_reg;
    logic                        busy_reg;
    logic                        new_set_reg;
    logic                        hash_done;
    logic [63:0]                 hash;
    logic                        tab_done;
    cvw_pkg::result_t            tab_res;
    logic                        out_valid_reg;
    cvw_pkg::result_t            out_reg;
    logic                        in_xfer;
    logic                        tab_start;

    assign in_stall = busy_reg || out_valid_reg;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= cvw_pkg::SCALE_W'(100000);
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                scale_reg <= cfg_data;
            if (in_xfer)
            begin
                busy_reg    <= 1'b1;
                new_set_reg <= in_data.new_set;
            end
            if (tab_done)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                out_reg       <= tab_res;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign tab_start = hash_done;

    cvw_hash #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_xfer),
        .coords     ({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
        .weld_scale (scale_reg),
        .done       (hash_done),
        .hash       (hash)
    );

    cvw_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tab_start),
        .new_set (new_set_reg),
        .hash    (hash),
        .done    (tab_done),
        .result  (tab_res)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_xfer) else $error("transfer accepted while busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tab_done |-> busy_reg) else $error("result without pending point");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.inserted && out_reg.overflow))
        else $error("inserted and overflow both set");

endmodule

// ===== rtl/cvw_hash.sv =====
// cvw_hash: quantises three coordinates and folds them into an fnv-1a 64-bit hash
// one coordinate at a time, the prime multiply split into 32x32 partial products over cycles
// depends on cvw_pkg
module cvw_hash #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [95:0]                    coords,
    input  logic [cvw_pkg::SCALE_W-1:0]    weld_scale,
    output logic                           done,
    output logic [63:0]                    hash
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QMUL,
        S_QRND,
        S_PLO,
        S_PHI,
        S_PSUM
    } state_t;

    state_t        state_reg;
    logic [1:0]    idx_reg;
    logic [63:0]   h_reg;
    logic [95:0]   coords_reg;
    logic          neg_reg;
    logic [52:0]   prod_reg;
    logic [63:0]   x_reg;
    logic [63:0]   plo_reg;
    logic [31:0]   phi_reg;
    logic          done_reg;

    logic [31:0]   cur;
    logic          cur_neg;
    logic [31:0]   cur_mag;
    logic [52:0]   rnd;
    logic [63:0]   q;

    assign cur     = coords_reg[95 - 32*idx_reg -: 32];
    assign cur_neg = cur[31];
    assign cur_mag = cur_neg ? (~cur + 32'd1) : cur;

    always_comb
    begin
        if (FRAC_BITS == 0)
            rnd = prod_reg;
        else
            rnd = (prod_reg + (53'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        q = neg_reg ? (~{11'd0, rnd} + 64'd1) : {11'd0, rnd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        coords_reg <= coords;
                        h_reg      <= cvw_pkg::FNV_BASIS;
                        idx_reg    <= 2'd0;
                        state_reg  <= S_QMUL;
                    end
                end
                S_QMUL:
                begin
                    neg_reg   <= cur_neg;
                    prod_reg  <= 53'(cur_mag) * 53'(weld_scale);
                    state_reg <= S_QRND;
                end
                S_QRND:
                begin
                    x_reg     <= h_reg ^ q;
                    state_reg <= S_PLO;
                end
                S_PLO:
                begin
                    // prime is {0x100, 0x1b3}: low x low, then cross terms
                    plo_reg   <= x_reg[31:0] * cvw_pkg::FNV_PRIME[31:0];
                    state_reg <= S_PHI;
                end
                S_PHI:
                begin
                    phi_reg   <= 32'(x_reg[63:32] * cvw_pkg::FNV_PRIME[31:0])
                               + 32'(x_reg[31:0] * cvw_pkg::FNV_PRIME[63:32]);
                    state_reg <= S_PSUM;
                end
                S_PSUM:
                begin
                    h_reg <= plo_reg + {phi_reg, 32'd0};
                    if (idx_reg == 2'd2)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_QMUL;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

// ===== rtl/cvw_table.sv =====
// cvw_table: linear-probed hash table held in one synchronous memory
// epoch marks clear on new_set, probes one slot at a time, each a read then a check
// depends on cvw_pkg
module cvw_table #(
    parameter int unsigned ENTRIES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                new_set,
    input  logic [63:0]         hash,
    output logic                done,
    output cvw_pkg::result_t    result
);

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned IDL = (ENTRIES < 4096) ? ENTRIES : 4096;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_CHECK
    } state_t;

    typedef struct packed {
        logic [7:0]  epoch;
        logic [63:0] key;
        logic [11:0] id;
    } entry_t;

    entry_t mem [ENTRIES];
    entry_t rd_reg;

    state_t            state_reg;
    logic [7:0]        epoch_reg;
    logic              cleared_reg;
    logic [AW-1:0]     slot_reg;
    logic [CW-1:0]     cnt_reg;
    logic [12:0]       next_id_reg;
    logic [63:0]       key_reg;
    logic              we;
    logic              done_reg;
    cvw_pkg::result_t  res_reg;
    logic              valid_slot;
    logic              pend_reg;
    logic              go;
    logic              wrap;

    // entries with a stale epoch count as empty; wrap of epoch forces a sweep
    logic              sweep_reg;
    logic [AW-1:0]     sweep_addr_reg;

    assign valid_slot = cleared_reg && (rd_reg.epoch == epoch_reg);
    assign we = (state_reg == T_CHECK) && !valid_slot && (next_id_reg < 13'(IDL));
    assign go = (start || pend_reg) && (state_reg == T_IDLE) && !sweep_reg;
    assign wrap = go && new_set && (epoch_reg == 8'hFE);

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
            mem[sweep_addr_reg] <= '{epoch: 8'hFF, key: '0, id: '0};
        else if (we)
            mem[slot_reg] <= '{epoch: epoch_reg, key: key_reg, id: next_id_reg[11:0]};
        rd_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            epoch_reg      <= 8'd0;
            cleared_reg    <= 1'b0;
            next_id_reg    <= 13'd0;
            done_reg       <= 1'b0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            // a start waits here until the table is idle and swept
            pend_reg <= (start || pend_reg) && !(go && !wrap);
            if (sweep_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == AW'(ENTRIES - 1))
                begin
                    sweep_reg   <= 1'b0;
                    cleared_reg <= 1'b1;
                end
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (go)
                    begin
                        if (wrap)
                        begin
                            // epoch wraps: sweep stale marks to the reserved value first
                            sweep_reg      <= 1'b1;
                            sweep_addr_reg <= '0;
                            epoch_reg      <= 8'hFF;
                        end
                        else
                        begin
                            if (new_set)
                            begin
                                next_id_reg <= 13'd0;
                                epoch_reg   <= epoch_reg + 8'd1;
                            end
                            key_reg   <= hash;
                            slot_reg  <= hash[AW-1:0];
                            cnt_reg   <= '0;
                            state_reg <= T_READ;
                        end
                    end
                end
                T_READ:
                    state_reg <= T_CHECK;
                T_CHECK:
                begin
                    if (valid_slot && rd_reg.key == key_reg)
                    begin
                        res_reg   <= '{vertex_id: rd_reg.id, inserted: 1'b0, overflow: 1'b0};
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                    else if (!valid_slot)
                    begin
                        if (we)
                        begin
                            res_reg     <= '{vertex_id: next_id_reg[11:0], inserted: 1'b1,
                                             overflow: 1'b0};
                            next_id_reg <= next_id_reg + 13'd1;
                        end
                        else
                            res_reg <= '{vertex_id: 12'd0, inserted: 1'b0, overflow: 1'b1};
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                    else if (cnt_reg == CW'(ENTRIES - 1))
                    begin
                        res_reg   <= '{vertex_id: 12'd0, inserted: 1'b0, overflow: 1'b1};
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= T_READ;
                    end
                end
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== dv/corner_vertex_welder_tb.sv =====
// corner_vertex_welder_tb: self-checking testbench for the corner vertex welder
// predicts quantise, fnv-1a fold and linear-probed id table per point transfer
// depends on cvw_pkg and corner_vertex_welder
`timescale 1ns / 100ps

module corner_vertex_welder_tb;

    localparam int unsigned ENTRIES = 4096;
    localparam int unsigned FRAC = 16;
    localparam int unsigned ID_CAP = (ENTRIES < 4096) ? ENTRIES : 4096;
    localparam longint unsigned CYCLE_LIMIT = 64'd1000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [cvw_pkg::SCALE_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    cvw_pkg::point_t in_data;
    logic out_valid;
    logic out_stall;
    cvw_pkg::result_t out_data;

    logic [63:0] key_mem [ENTRIES];
    logic [11:0] id_mem [ENTRIES];
    bit live_mem [ENTRIES];
    int unsigned id_count;
    logic [cvw_pkg::SCALE_W-1:0] scale_reg;

    cvw_pkg::result_t pending_ids [$];
    int errors;
    longint unsigned cycles;
    bit no_idle;

    corner_vertex_welder u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("corner_vertex_welder verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] quantise(logic [31:0] bits);
        logic [63:0] mag;
        logic [63:0] q;
        mag = bits[31] ? {32'd0, (~bits + 32'd1)} : {32'd0, bits};
        if (bits[31] && mag == 64'd0)
            mag = 64'h80000000;
        q = mag * {43'd0, scale_reg};
        if (FRAC != 0)
            q = (q + (64'd1 << (FRAC - 1))) >> FRAC;
        return bits[31] ? (~q + 64'd1) : q;
    endfunction

    function automatic cvw_pkg::result_t weld_point(cvw_pkg::point_t p);
        logic [63:0] h;
        int unsigned slot;
        cvw_pkg::result_t r;
        bit done;
        r = '0;
        done = 1'b0;
        if (p.new_set)
        begin
            foreach (live_mem[i])
                live_mem[i] = 1'b0;
            id_count = 0;
        end
        h = cvw_pkg::FNV_BASIS;
        h = (h ^ quantise(p.pos_x)) * cvw_pkg::FNV_PRIME;
        h = (h ^ quantise(p.pos_y)) * cvw_pkg::FNV_PRIME;
        h = (h ^ quantise(p.pos_z)) * cvw_pkg::FNV_PRIME;
        slot = h % ENTRIES;
        for (int n = 0; n < ENTRIES && !done; n++)
        begin
            if (live_mem[slot])
            begin
                if (key_mem[slot] == h)
                begin
                    r.vertex_id = id_mem[slot];
                    done = 1'b1;
                end
            end
            else
            begin
                if (id_count < ID_CAP)
                begin
                    live_mem[slot] = 1'b1;
                    key_mem[slot] = h;
                    id_mem[slot] = id_count[11:0];
                    r.vertex_id = id_count[11:0];
                    r.inserted = 1'b1;
                    id_count++;
                end
                else
                    r.overflow = 1'b1;
                done = 1'b1;
            end
            slot = (slot + 1) % ENTRIES;
        end
        if (!done)
            r.overflow = 1'b1;
        return r;
    endfunction

    // result side: random stall per result, check on transfer
    initial
    begin
        int unsigned wait_n;
        cvw_pkg::result_t exp_r;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            do
                @(posedge clk);
            while (!out_valid);
            wait_n = no_idle ? 0 : $urandom_range(0, 13);
            repeat (wait_n) @(negedge clk);
            @(negedge clk);
            out_stall = 1'b0;
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_ids.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    exp_r = pending_ids.pop_front();
                    if (out_data.vertex_id !== exp_r.vertex_id)
                    begin
                        $error("vertex_id expected %0d actual %0d",
                               exp_r.vertex_id, out_data.vertex_id);
                        errors++;
                    end
                    if (out_data.inserted !== exp_r.inserted)
                    begin
                        $error("inserted expected %0d actual %0d",
                               exp_r.inserted, out_data.inserted);
                        errors++;
                    end
                    if (out_data.overflow !== exp_r.overflow)
                    begin
                        $error("overflow expected %0d actual %0d",
                               exp_r.overflow, out_data.overflow);
                        errors++;
                    end
                end
            end
            @(negedge clk);
            out_stall = 1'b1;
        end
    end

    task automatic send_point(cvw_pkg::point_t p);
        int unsigned gap;
        cvw_pkg::result_t exp_r;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        repeat (gap) @(negedge clk);
        in_data = p;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        exp_r = weld_point(p);
        pending_ids = {pending_ids, exp_r};
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 200) @(posedge clk);
    endtask

    task automatic write_scale(logic [cvw_pkg::SCALE_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_data = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        scale_reg = v;
    endtask

    function automatic cvw_pkg::point_t make_point(bit ns, logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
        cvw_pkg::point_t p;
        p.new_set = ns;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        return p;
    endfunction

    function automatic logic [31:0] rand_coord(int unsigned range_sel);
        case (range_sel)
            0: return $urandom;
            1: return $urandom_range(0, 12) << 14;
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        endcase
    endfunction

    task automatic test_extremes();
        send_point(make_point(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h0));
        send_point(make_point(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h0));
        send_point(make_point(1'b0, 32'hFFFFFFFF, 32'h00000001, 32'hFFFF8000));
        send_point(make_point(1'b0, 32'h00008000, 32'hFFFF8000, 32'h00007FFF));
        send_point(make_point(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_point(make_point(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    endtask

    task automatic test_scale_corners();
        write_scale(0);
        send_point(make_point(1'b1, 32'h12345678, 32'h80000000, 32'h7FFFFFFF));
        send_point(make_point(1'b0, 32'h00000001, 32'hDEADBEEF, 32'h0));
        write_scale(21'h1FFFFF);
        send_point(make_point(1'b0, 32'h80000000, 32'h80000000, 32'h80000000));
        send_point(make_point(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        write_scale(1);
        send_point(make_point(1'b1, 32'h00008000, 32'hFFFF8000, 32'h00017FFF));
        send_point(make_point(1'b0, 32'h00008000, 32'hFFFF8000, 32'h00017FFF));
        write_scale(21'd100000);
    endtask

    // coarse scale, back to back points with repeats that weld
    task automatic test_coarse_weld();
        write_scale(21'd65536);
        no_idle = 1'b1;
        send_point(make_point(1'b1, 32'h0, 32'h0, 32'h0));
        for (int i = 1; i < 200; i++)
            send_point(make_point(1'b0, i << 16, 32'h0, 32'h0));
        send_point(make_point(1'b0, 32'h0, 32'h0, 32'h0));
        send_point(make_point(1'b0, 32'h00050000, 32'h0, 32'h0));
        no_idle = 1'b0;
        send_point(make_point(1'b1, 32'h00050000, 32'h0, 32'h0));
    endtask

    task automatic test_random();
        logic [cvw_pkg::SCALE_W-1:0] scales [4];
        cvw_pkg::point_t seen [$];
        cvw_pkg::point_t p;
        scales = '{21'd100000, 21'd1, 21'd65536, 21'($urandom_range(1, 1048576))};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_scale(scales[ph]);
            seen.delete();
            for (int i = 0; i < 408; i++)
            begin
                no_idle = ((i / 60) % 3 == 2);
                if (seen.size() != 0 && $urandom_range(0, 2) == 0)
                begin
                    p = seen[$urandom_range(0, seen.size() - 1)];
                    p.new_set = 1'b0;
                end
                else
                begin
                    p = make_point($urandom_range(0, 99) == 0,
                                   rand_coord($urandom_range(0, 2)),
                                   rand_coord($urandom_range(0, 2)),
                                   rand_coord($urandom_range(0, 2)));
                    if (p.new_set)
                        seen.delete();
                    seen = {seen, p};
                end
                send_point(p);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        scale_reg = 21'd100000;
        id_count = 0;
        foreach (live_mem[i])
            live_mem[i] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_scale_corners();
        test_coarse_weld();
        test_random();
        drain();
        if (errors == 0)
            $display("corner_vertex_welder verification clean");
        else
            $display("corner_vertex_welder verification failed");
        $finish;
    end
endmodule
